[rtl/ir_pulse_distance_decoder_macros.svh]
// Assertion macros shared by the checker of the IR pulse-distance decoder.
// Needs a clk_i and an active-low rst_ni in the scope that uses them.
`ifndef IR_PULSE_DISTANCE_DECODER_MACROS_SVH
`define IR_PULSE_DISTANCE_DECODER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define IRPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("irpd assertion failed");

// Checks a property on every rising clock edge, reset included.
`define IRPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("irpd assertion failed");

`endif

[rtl/irpd_pkg.sv]
`timescale 1ns / 1ps
// Package of the IR pulse-distance decoder: frame status codes, register
// defaults and the types passed between its modules. No dependencies.
package irpd_pkg;

  localparam logic [1:0] ST_CODE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REPEAT = 2'd2;
  localparam logic [1:0] ST_FAIL   = 2'd3;

  localparam logic [31:0] THRESHOLD_RST = 32'd66000;
  localparam logic [31:0] PERIOD_RST    = 32'd272000;

  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_SAT = 6'd63;

  // Register indexes on the configuration port.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_PERIOD    = 1'b1;

  typedef struct packed {
    logic [31:0] bit_threshold;
    logic [31:0] frame_period;
  } irpd_cfg_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] code;
  } irpd_result_t;

endpackage

[rtl/irpd_edge_if.sv]
`timescale 1ns / 1ps
// Input channel of the decoder: one tick request carrying the edge flag.
// No dependencies.
interface irpd_edge_if;
  logic valid;
  logic ready;
  logic edge_req;

  modport source (output valid, output edge_req, input ready);
  modport sink (input valid, input edge_req, output ready);
endinterface

[rtl/irpd_frame_if.sv]
`timescale 1ns / 1ps
// Output channel of the decoder: one request per closed frame.
// No dependencies.
interface irpd_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [31:0] code;

  modport source (output valid, output frame_status, output code, input ready);
  modport sink (input valid, input frame_status, input code, output ready);
endinterface

[rtl/irpd_cfg_regs.sv]
`timescale 1ns / 1ps
// APB-style register file holding the bit threshold and the frame period.
// Depends on irpd_pkg.
module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output irpd_cfg_t   cfg_o
);

  logic [31:0] threshold_q;
  logic [31:0] period_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      period_q    <= PERIOD_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_THRESHOLD: threshold_q <= pwdata;
        REG_PERIOD:    period_q    <= pwdata;
        default:       threshold_q <= threshold_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = threshold_q;
      REG_PERIOD:    prdata = period_q;
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.bit_threshold = threshold_q;
  assign cfg_o.frame_period  = period_q;

endmodule

[rtl/irpd_in_reg.sv]
`timescale 1ns / 1ps
// Input register: holds one accepted tick until the frame logic consumes it.
// Depends on irpd_pkg.
module irpd_in_reg
  import irpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_edge_i,
  output logic in_ready_o,
  input  logic take_i,
  output logic held_valid_o,
  output logic held_edge_o
);

  logic valid_q;
  logic valid_d;
  logic edge_q;

  // The slot refills in the same cycle that the frame logic drains it.
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      edge_q <= in_edge_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_edge_o  = edge_q;

endmodule

[rtl/irpd_frame_core.sv]
`timescale 1ns / 1ps
// Frame state of the decoder: timer, edge stamps, edge count, code shifter
// and the frame classification. Depends on irpd_pkg.
module irpd_frame_core
  import irpd_pkg::*;
#(
  parameter int CODE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  irpd_cfg_t    cfg_i,
  input  logic         step_i,
  input  logic         edge_i,
  output logic         close_o,
  output irpd_result_t res_o
);

  localparam int FullCount = CODE_BITS + 2;
  localparam bit FullReachable = (FullCount <= 63);

  logic [31:0]          timer_q, timer_d, timer_a, timer_b;
  logic                 running_q, running_d, run_a;
  logic [31:0]          last_q, last_d, last_a;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_a;
  logic [CODE_BITS-1:0] shift_q, shift_d, shift_a;
  logic [31:0]          gap;
  logic                 bit_one, in_window, close, full_hit;

  always_comb begin
    // Edge handling comes first; the first edge starts the timer at zero.
    timer_a   = (edge_i && !running_q) ? '0 : timer_q;
    run_a     = running_q || edge_i;
    in_window = (cnt_q != '0) && ({26'd0, cnt_q} <= 32'(CODE_BITS));
    gap       = timer_a - last_q;
    bit_one   = gap > cfg_i.bit_threshold;
    shift_a   = (edge_i && in_window) ? {shift_q[CODE_BITS-2:0], bit_one} : shift_q;
    last_a    = edge_i ? timer_a : last_q;
    cnt_a     = (edge_i && cnt_q != CNT_SAT) ? cnt_q + 6'd1 : cnt_q;
    // Then the timer advances and is checked against the period.
    timer_b   = run_a ? timer_a + 32'd1 : timer_a;
    close     = run_a && (timer_b >= cfg_i.frame_period);
    full_hit  = FullReachable && (cnt_a == 6'(FullCount));
  end

  always_comb begin
    res_o.code = '0;
    if (full_hit) begin
      res_o.code         = 32'(shift_a);
      res_o.frame_status = (shift_a != '0) ? ST_CODE : ST_EMPTY;
    end else if (cnt_a == 6'd2) begin
      res_o.frame_status = ST_REPEAT;
    end else begin
      res_o.frame_status = ST_FAIL;
    end
  end

  assign close_o = close;

  always_comb begin
    timer_d   = timer_q;
    running_d = running_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    if (step_i) begin
      if (close) begin
        timer_d   = '0;
        running_d = 1'b0;
        last_d    = '0;
        cnt_d     = '0;
        shift_d   = '0;
      end else begin
        timer_d   = timer_b;
        running_d = run_a;
        last_d    = last_a;
        cnt_d     = cnt_a;
        shift_d   = shift_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= '0;
      running_q <= 1'b0;
      last_q    <= '0;
      cnt_q     <= '0;
      shift_q   <= '0;
    end else begin
      timer_q   <= timer_d;
      running_q <= running_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
    end
  end

endmodule

[rtl/irpd_out_reg.sv]
`timescale 1ns / 1ps
// Output register: holds one frame result until the sink takes it.
// Depends on irpd_pkg.
module irpd_out_reg
  import irpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  irpd_result_t res_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic         free_o,
  output irpd_result_t res_o
);

  logic         valid_q;
  logic         valid_d;
  irpd_result_t res_q;

  // Free when empty or emptied at this edge.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[rtl/ir_pulse_distance_decoder.sv]
`timescale 1ns / 1ps
// Top level of the pulse-distance IR frame decoder.
// Depends on irpd_pkg, irpd_edge_if, irpd_frame_if and the irpd_* modules.
//
//   channel   direction  payload                     meaning
//   edge_i    in         edge_req                    one timer tick
//   frame_o   out        frame_status, code          one closed frame
//   APB       in/out     bit_threshold, frame_period configuration
//
// Each accepted request is one timer tick. It is held in the input register
// until the frame logic consumes it, so while no result waits on frame_o a new
// request can be accepted in every cycle and the sustained rate is one tick
// per clock. A frame result enters the output register as its closing tick is
// consumed. Reset clears the frame state and restores the register defaults.
// While a result waits on frame_o, no tick is consumed, because any tick may
// close a frame; the input register takes one more tick and edge_i then drops
// ready until the result is taken.
module ir_pulse_distance_decoder
  import irpd_pkg::*;
#(
  parameter int CODE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  irpd_edge_if.sink          edge_i,
  irpd_frame_if.source       frame_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  irpd_cfg_t    cfg;
  irpd_result_t core_res;
  irpd_result_t out_res;
  logic         held_valid;
  logic         held_edge;
  logic         out_free;
  logic         step;
  logic         close;

  // Both registers live in a small APB register file.
  irpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A tick is consumed only when the output register could take a result,
  // because any tick may close a frame.
  assign step = held_valid && out_free;

  irpd_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (edge_i.valid),
    .in_edge_i    (edge_i.edge_req),
    .in_ready_o   (edge_i.ready),
    .take_i       (step),
    .held_valid_o (held_valid),
    .held_edge_o  (held_edge)
  );

  // The timer, the stamps and the code shifter change only on a consumed tick.
  irpd_frame_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (step),
    .edge_i  (held_edge),
    .close_o (close),
    .res_o   (core_res)
  );

  irpd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && close),
    .res_i       (core_res),
    .out_ready_i (frame_o.ready),
    .out_valid_o (frame_o.valid),
    .free_o      (out_free),
    .res_o       (out_res)
  );

  assign frame_o.frame_status = out_res.frame_status;
  assign frame_o.code         = out_res.code;

endmodule

[rtl/irpd_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the IR pulse-distance decoder, bound to its top.
// Depends on irpd_pkg and ir_pulse_distance_decoder_macros.svh.
`include "ir_pulse_distance_decoder_macros.svh"

module irpd_checker
  import irpd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  frame_status_i,
  input logic [31:0] code_i
);

  // A stalled result stays put.
  `IRPD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_status_i) && $stable(code_i))

  // Only a received code carries bits, and it is never zero.
  `IRPD_ASSERT(a_code_zero, out_valid_i && frame_status_i != ST_CODE |-> code_i == 32'd0)
  `IRPD_ASSERT(a_code_nonzero, out_valid_i && frame_status_i == ST_CODE |-> code_i != 32'd0)

  // With no result pending the tick input is never held off.
  `IRPD_ASSERT_ALWAYS(a_in_ready, !out_valid_i |-> in_ready_i)

endmodule

bind ir_pulse_distance_decoder irpd_checker u_irpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (edge_i.ready),
  .out_valid_i    (frame_o.valid),
  .out_ready_i    (frame_o.ready),
  .frame_status_i (frame_o.frame_status),
  .code_i         (frame_o.code)
);
